FILE: rtl/core/mi3_pkg.sv
// shared constants, types and result limits for the 3x3 adjugate inverse
// no dependencies; every other file of the block imports this package
package mi3_pkg;

  localparam int W      = 32;           // element width, signed fixed point
  localparam int F      = 16;           // fraction bits of an element
  localparam int CW     = 2 * W + 1;    // signed cofactor width
  localparam int CMW    = CW - 1;       // cofactor magnitude width
  localparam int DW     = 3 * W + 1;    // signed determinant width
  localparam int MW     = DW - 1;       // determinant magnitude width
  localparam int NW     = CMW + 2 * F;  // scaled numerator width
  localparam int TW     = NW - W;       // numerator part above the quotient bits
  localparam int NCOF   = 9;
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [W-1:0] WMAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W - 1){1'b0}}};

  typedef logic signed [W-1:0]   word_t;
  typedef logic signed [2*W-1:0] prod_t;
  typedef logic signed [CW-1:0]  cof_t;
  typedef logic signed [DW-1:0]  det_t;

  // one classified matrix waiting for division, cofactors in output order
  typedef struct packed {
    logic [NCOF-1:0][CMW-1:0] mag;
    logic [NCOF-1:0]          neg;
    logic [MW-1:0]            det_mag;
    logic                     det_neg;
    logic                     singular;
  } mi3_job_t;

endpackage

FILE: rtl/core/mi3_in_if.sv
// input channel of the inverse block: one matrix per word
// depends on mi3_pkg
interface mi3_in_if import mi3_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

FILE: rtl/core/mi3_out_if.sv
// output channel of the inverse block: inverse matrix plus flags per word
// depends on mi3_pkg
interface mi3_out_if import mi3_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
  logic  singular;
  logic  saturated;

  modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
                  inv22, singular, saturated, input ready);
  modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
                  inv22, singular, saturated, output ready);
endinterface

FILE: rtl/core/mi3_front.sv
// front pipeline: cofactors, determinant, magnitudes and singular check
// depends on mi3_pkg and mi3_in_if
module mi3_front import mi3_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  mi3_in_if.sink   in_i,
  output logic     push_valid_o,
  output mi3_job_t push_job_o,
  input  logic     push_ready_i
);

  localparam int NST = 6;

  logic [NST-1:0] v_q;
  logic           en;

  word_t opa [NCOF], opb [NCOF], opc [NCOF], opd [NCOF];

  prod_t pp_q [NCOF], pn_q [NCOF];
  word_t r1_q [3], r2_q [3];
  cof_t  cof2_q [NCOF], cof3_q [NCOF], cof4_q [NCOF], cof5_q [NCOF];
  cof_t  plo_q [3], phi_q [3];
  det_t  term_q [3];
  det_t  det_q;
  mi3_job_t job_d, job_q;

  assign en           = !v_q[NST-1] || push_ready_i;
  assign in_i.ready   = en;
  assign push_valid_o = v_q[NST-1];
  assign push_job_o   = job_q;

  // cofactor = opa*opb - opc*opd, in output order
  always_comb begin
    opa[0] = in_i.m11; opb[0] = in_i.m22; opc[0] = in_i.m12; opd[0] = in_i.m21;
    opa[1] = in_i.m02; opb[1] = in_i.m21; opc[1] = in_i.m01; opd[1] = in_i.m22;
    opa[2] = in_i.m01; opb[2] = in_i.m12; opc[2] = in_i.m02; opd[2] = in_i.m11;
    opa[3] = in_i.m12; opb[3] = in_i.m20; opc[3] = in_i.m10; opd[3] = in_i.m22;
    opa[4] = in_i.m00; opb[4] = in_i.m22; opc[4] = in_i.m02; opd[4] = in_i.m20;
    opa[5] = in_i.m02; opb[5] = in_i.m10; opc[5] = in_i.m00; opd[5] = in_i.m12;
    opa[6] = in_i.m10; opb[6] = in_i.m21; opc[6] = in_i.m11; opd[6] = in_i.m20;
    opa[7] = in_i.m01; opb[7] = in_i.m20; opc[7] = in_i.m00; opd[7] = in_i.m21;
    opa[8] = in_i.m00; opb[8] = in_i.m11; opc[8] = in_i.m01; opd[8] = in_i.m10;
  end

  always_comb begin
    cof_t neg_c;
    det_t neg_d;
    job_d = '0;
    for (int k = 0; k < NCOF; k++) begin
      neg_c          = -cof5_q[k];
      job_d.neg[k]   = cof5_q[k][CW-1];
      job_d.mag[k]   = cof5_q[k][CW-1] ? neg_c[CMW-1:0] : cof5_q[k][CMW-1:0];
    end
    neg_d          = -det_q;
    job_d.det_neg  = det_q[DW-1];
    job_d.det_mag  = det_q[DW-1] ? neg_d[MW-1:0] : det_q[MW-1:0];
    job_d.singular = (det_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NCOF; k++) begin
        pp_q[k]   <= opa[k] * opb[k];
        pn_q[k]   <= opc[k] * opd[k];
        cof2_q[k] <= cof_t'(pp_q[k]) - cof_t'(pn_q[k]);
        cof3_q[k] <= cof2_q[k];
        cof4_q[k] <= cof3_q[k];
        cof5_q[k] <= cof4_q[k];
      end
      r1_q[0] <= in_i.m00;
      r1_q[1] <= in_i.m01;
      r1_q[2] <= in_i.m02;
      r2_q    <= r1_q;
      // row 0 times cofactors split into low and high halves
      for (int j = 0; j < 3; j++) begin
        plo_q[j]  <= r2_q[j] * $signed({1'b0, cof2_q[3*j][W-1:0]});
        phi_q[j]  <= r2_q[j] * $signed(cof2_q[3*j][CW-1:W]);
        term_q[j] <= (det_t'(phi_q[j]) <<< W) + det_t'(plo_q[j]);
      end
      det_q <= term_q[0] + term_q[1] + term_q[2];
      job_q <= job_d;
    end
  end

endmodule

FILE: rtl/core/mi3_queue.sv
// short job queue between the front and the divider back end
// depends on mi3_pkg
module mi3_queue import mi3_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  mi3_job_t push_job_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output mi3_job_t pop_job_o
);

  mi3_job_t       mem_q [QDEPTH];
  logic [QAW-1:0] wr_q, rd_q;
  logic [QAW:0]   cnt_q;
  logic           push, pop;

  assign push_ready_o = (cnt_q != (QAW + 1)'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QAW + 1)'(push) - (QAW + 1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_job_i;
  end

endmodule

FILE: rtl/core/mi3_back.sv
// back end: nine restoring dividers, one quotient bit per stage, then saturation
// depends on mi3_pkg and mi3_out_if
module mi3_back import mi3_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     pop_valid_i,
  output logic     pop_ready_o,
  input  mi3_job_t pop_job_i,
  mi3_out_if.source out_o
);

  logic en;

  logic [W:0]          vb_q;
  logic [MW-1:0]       rem_q  [W+1][NCOF];
  logic [W-1:0]        quo_q  [W+1][NCOF];
  logic [W-1:0]        low_q  [W+1][NCOF];
  logic [NCOF-1:0]     neg_q  [W+1];
  logic [NCOF-1:0]     big_q  [W+1];
  logic [MW-1:0]       d_q    [W+1];
  logic [W:0]          sing_q;

  word_t inv_d [NCOF], inv_q [NCOF];
  logic  sat_d, sat_q, osing_q, vo_q;

  assign en          = !vo_q || out_o.ready;
  assign pop_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= '0;
      vo_q <= 1'b0;
    end else if (en) begin
      vb_q <= {vb_q[W-1:0], pop_valid_i};
      vo_q <= vb_q[W];
    end
  end

  // entry stage: scale numerator, check quotient range, load remainder
  always_ff @(posedge clk_i) begin
    logic [NW-1:0] num;
    if (en) begin
      for (int k = 0; k < NCOF; k++) begin
        num           = {pop_job_i.mag[k], {(2 * F){1'b0}}};
        rem_q[0][k]  <= MW'(num[NW-1:W]);
        low_q[0][k]  <= num[W-1:0];
        quo_q[0][k]  <= '0;
        big_q[0][k]  <= (MW'(num[NW-1:W]) >= pop_job_i.det_mag);
        neg_q[0][k]  <= (pop_job_i.neg[k] ^ pop_job_i.det_neg) && (pop_job_i.mag[k] != '0);
      end
      d_q[0]    <= pop_job_i.det_mag;
      sing_q[0] <= pop_job_i.singular;
    end
  end

  for (genvar s = 1; s <= W; s++) begin : g_step
    always_ff @(posedge clk_i) begin
      logic [MW:0] r2, diff;
      logic        ge;
      if (en) begin
        for (int k = 0; k < NCOF; k++) begin
          r2   = {rem_q[s-1][k], low_q[s-1][k][W-1]};
          diff = r2 - {1'b0, d_q[s-1]};
          ge   = (r2 >= {1'b0, d_q[s-1]});
          rem_q[s][k] <= ge ? diff[MW-1:0] : r2[MW-1:0];
          quo_q[s][k] <= {quo_q[s-1][k][W-2:0], ge};
          low_q[s][k] <= {low_q[s-1][k][W-2:0], 1'b0};
        end
        neg_q[s]  <= neg_q[s-1];
        big_q[s]  <= big_q[s-1];
        d_q[s]    <= d_q[s-1];
        sing_q[s] <= sing_q[s-1];
      end
    end
  end

  always_comb begin
    logic [W-1:0] q;
    logic         lsat;
    sat_d = 1'b0;
    for (int k = 0; k < NCOF; k++) begin
      q = quo_q[W][k];
      if (!neg_q[W][k]) begin
        lsat     = big_q[W][k] || q[W-1];
        inv_d[k] = lsat ? WMAX : q;
      end else begin
        lsat     = big_q[W][k] || (q > WMIN);
        inv_d[k] = lsat ? WMIN : -q;
      end
      if (sing_q[W]) begin
        inv_d[k] = '0;
        lsat     = 1'b0;
      end
      sat_d = sat_d | lsat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inv_q   <= inv_d;
      sat_q   <= sat_d;
      osing_q <= sing_q[W];
    end
  end

  assign out_o.valid     = vo_q;
  assign out_o.inv00     = inv_q[0];
  assign out_o.inv01     = inv_q[1];
  assign out_o.inv02     = inv_q[2];
  assign out_o.inv10     = inv_q[3];
  assign out_o.inv11     = inv_q[4];
  assign out_o.inv12     = inv_q[5];
  assign out_o.inv20     = inv_q[6];
  assign out_o.inv21     = inv_q[7];
  assign out_o.inv22     = inv_q[8];
  assign out_o.singular  = osing_q;
  assign out_o.saturated = sat_q;

endmodule

FILE: rtl/core/matrix_inverse_3x3.sv
// 3x3 matrix inverse by the adjugate, Q16.16 in and out. Takes one matrix a
// clock unless stalled and returns one result word per matrix, in order. With
// no back pressure a matrix passes six front stages, one queue slot, one
// divider entry stage, 32 divider stages and the output register. The 32-stage
// restoring divider sets the depth (one quotient bit per stage, nine lanes side
// by side); throughput is one matrix per cycle when nothing stalls. A zero
// determinant gives singular=1 and an all-zero inverse; out-of-range elements
// clip and set saturated. Quotients round toward zero.
// depends on mi3_pkg, mi3_in_if, mi3_out_if, mi3_front, mi3_queue, mi3_back
module matrix_inverse_3x3 import mi3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  mi3_in_if.sink    in_i,
  mi3_out_if.source out_o
);

  // front to queue
  logic     push_valid, push_ready;
  mi3_job_t push_job;
  // queue to back end
  logic     pop_valid, pop_ready;
  mi3_job_t pop_job;

  // exact cofactors and determinant, stalls only when the queue is full
  mi3_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .push_valid_o(push_valid),
    .push_job_o  (push_job),
    .push_ready_i(push_ready)
  );

  // decouples the two halves so each stalls on its own
  mi3_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_job_i  (push_job),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_job_o   (pop_job)
  );

  // pipelined dividers and the output register
  mi3_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_job_i  (pop_job),
    .out_o      (out_o)
  );

endmodule

FILE: rtl/core/mi3_checker.sv
// port level checks for the inverse block, bound to the top level
// depends on mi3_pkg
module mi3_checker import mi3_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_i,
  input logic  out_valid_i,
  input logic  out_ready_i,
  input word_t inv00_i, inv01_i, inv02_i, inv10_i, inv11_i,
  input word_t inv12_i, inv20_i, inv21_i, inv22_i,
  input logic  singular_i,
  input logic  saturated_i
);

  logic [7:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 8'(in_acc) - 8'(out_acc);
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped before taken");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> pend_q != 8'd0)
    else $error("result without a matrix in flight");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && singular_i |-> !saturated_i && inv00_i == '0 && inv01_i == '0 &&
      inv02_i == '0 && inv10_i == '0 && inv11_i == '0 && inv12_i == '0 &&
      inv20_i == '0 && inv21_i == '0 && inv22_i == '0)
    else $error("singular result with nonzero elements");

  a_sat_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saturated_i |->
      inv00_i == WMAX || inv00_i == WMIN || inv01_i == WMAX || inv01_i == WMIN ||
      inv02_i == WMAX || inv02_i == WMIN || inv10_i == WMAX || inv10_i == WMIN ||
      inv11_i == WMAX || inv11_i == WMIN || inv12_i == WMAX || inv12_i == WMIN ||
      inv20_i == WMAX || inv20_i == WMIN || inv21_i == WMAX || inv21_i == WMIN ||
      inv22_i == WMAX || inv22_i == WMIN)
    else $error("saturated flag without a clipped element");

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .inv00_i    (out_o.inv00),
  .inv01_i    (out_o.inv01),
  .inv02_i    (out_o.inv02),
  .inv10_i    (out_o.inv10),
  .inv11_i    (out_o.inv11),
  .inv12_i    (out_o.inv12),
  .inv20_i    (out_o.inv20),
  .inv21_i    (out_o.inv21),
  .inv22_i    (out_o.inv22),
  .singular_i (out_o.singular),
  .saturated_i(out_o.saturated)
);
